/* design/asu_pkg.sv */
// asu_pkg: types, character codes and digit decode shared by the
// ascii_to_unsigned_parser modules; no dependencies
package asu_pkg;

   // parse phase of the current string
   typedef enum logic [2:0] {
      PH_SKIP   = 3'd0,
      PH_ZERO   = 3'd1,
      PH_DIGITS = 3'd2,
      PH_DRAIN  = 3'd3
   } phase_type;

   // decoded digit: ok is low for bytes that are not 0-9, a-f, A-F
   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } digit_type;

   localparam int CHAR_BITS  = 8;
   localparam int VALUE_BITS = 32;
   localparam int RADIX_BITS = 6;

   localparam logic [RADIX_BITS-1:0] RADIX_OCT = 6'd8;
   localparam logic [RADIX_BITS-1:0] RADIX_DEC = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_HEX = 6'd16;

   localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_F = 8'h46;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_F = 8'h66;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_X = 8'h78;

   // map one byte to its digit value
   function automatic digit_type digit_decode(input logic [CHAR_BITS-1:0] c);
      digit_type d;
      logic [CHAR_BITS-1:0] diff;
      d    = '0;
      diff = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         diff  = c - CH_ZERO;
         d.ok  = 1'b1;
         d.val = diff[3:0];
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         diff  = c - CH_LOWER_A + 8'd10;
         d.ok  = 1'b1;
         d.val = diff[3:0];
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         diff  = c - CH_UPPER_A + 8'd10;
         d.ok  = 1'b1;
         d.val = diff[3:0];
      end
      return d;
   endfunction

endpackage

/* design/asu_ifs.sv */
// asu_ifs: valid/ready channel interfaces for characters, results and the
// base select register; depends on asu_pkg

interface asu_req_if;
   import asu_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] character;
   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface asu_rsp_if #(parameter int OFFSET_BITS = 16);
   import asu_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic [OFFSET_BITS-1:0] end_offset;
   logic                  converted;
   modport source (output valid, output value, output end_offset, output converted,
                   input ready);
   modport sink   (input valid, input value, input end_offset, input converted,
                   output ready);
endinterface

interface asu_csr_if;
   import asu_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [RADIX_BITS-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* design/asu_in_stage.sv */
// asu_in_stage: input register holding one character word
// depends on asu_pkg and asu_req_if
module asu_in_stage
   import asu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   asu_req_if.sink              req_bus,
   input  logic                 advance,
   output logic                 held_valid,
   output logic [CHAR_BITS-1:0] held_char
);

   logic                 valid_ff, valid_in;
   logic [CHAR_BITS-1:0] char_ff, char_in;
   logic                 take;

   // take a new word when empty or when the held one moves on
   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      if (take) begin
         valid_in = 1'b1;
         char_in  = req_bus.character;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
   end

   assign held_valid = valid_ff;
   assign held_char  = char_ff;

endmodule

/* design/asu_core.sv */
// asu_core: parse state machine and digit accumulator, one character per cycle
// when fire is high; depends on asu_pkg
module asu_core
   import asu_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [CHAR_BITS-1:0]   character,
   input  logic [RADIX_BITS-1:0]  base_select,
   output logic                   emit,
   output logic [VALUE_BITS-1:0]  value,
   output logic [OFFSET_BITS-1:0] end_offset,
   output logic                   converted
);

   phase_type              phase_ff, phase_in;
   logic [RADIX_BITS-1:0]  radix_ff, radix_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] mark_ff, mark_in;
   logic                   seen_ff, seen_in;

   digit_type              dv;
   logic [RADIX_BITS-1:0]  radix_eff;
   logic [OFFSET_BITS-1:0] pos_sat;
   logic [VALUE_BITS-1:0]  acc_mac;
   logic                   is_ws, is_nul, is_x, zero_prefix;
   logic                   do_digit, dig_ok, bump, restart;

   // character classes
   assign dv          = digit_decode(character);
   assign is_ws       = (character >= CH_TAB && character <= CH_CR) || character == CH_SPACE;
   assign is_nul      = character == CH_NUL;
   assign is_x        = character == CH_LOWER_X || character == CH_UPPER_X;
   assign zero_prefix = base_select == '0 && character == CH_ZERO;

   // radix in force for this character
   always_comb begin
      case (phase_ff)
         PH_SKIP:  radix_eff = (base_select != '0) ? base_select : RADIX_DEC;
         PH_ZERO:  radix_eff = RADIX_OCT;
         default:  radix_eff = radix_ff;
      endcase
   end

   // does this character go through the digit step, and is it a digit
   assign do_digit = (phase_ff == PH_SKIP && !is_ws && !is_nul && !zero_prefix) ||
                     (phase_ff == PH_ZERO && !is_x) ||
                     (phase_ff == PH_DIGITS);
   assign dig_ok   = dv.ok && ({2'b00, dv.val} < radix_eff);

   // saturating position and multiply-add
   assign pos_sat = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
   assign acc_mac = acc_ff * VALUE_BITS'(radix_eff) + VALUE_BITS'(dv.val);

   assign bump    = (phase_ff == PH_SKIP && (is_ws || zero_prefix)) ||
                    (phase_ff == PH_ZERO && is_x) ||
                    (do_digit && dig_ok);
   assign restart = is_nul;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (phase_ff)
            PH_SKIP: begin
               if (is_ws || is_nul) begin
                  phase_in = PH_SKIP;
               end else if (zero_prefix) begin
                  phase_in = PH_ZERO;
               end else begin
                  phase_in = dig_ok ? PH_DIGITS : PH_DRAIN;
               end
            end
            PH_ZERO: begin
               if (is_x || dig_ok) begin
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = is_nul ? PH_SKIP : PH_DRAIN;
               end
            end
            PH_DIGITS: begin
               if (dig_ok) begin
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = is_nul ? PH_SKIP : PH_DRAIN;
               end
            end
            PH_DRAIN: phase_in = is_nul ? PH_SKIP : PH_DRAIN;
            default:  phase_in = PH_SKIP;
         endcase
      end
   end

   // datapath state and result word
   always_comb begin
      radix_in = radix_ff;
      acc_in   = acc_ff;
      pos_in   = pos_ff;
      mark_in  = mark_ff;
      seen_in  = seen_ff;
      emit     = fire && ((phase_ff == PH_SKIP && is_nul) || (do_digit && !dig_ok));
      if (fire) begin
         if (restart) begin
            radix_in = '0;
            acc_in   = '0;
            pos_in   = '0;
            mark_in  = '0;
            seen_in  = 1'b0;
         end else begin
            if (bump) begin
               pos_in = pos_sat;
            end
            if (phase_ff == PH_SKIP && zero_prefix) begin
               seen_in = 1'b1;
               mark_in = pos_sat;
            end
            if (phase_ff == PH_ZERO && is_x) begin
               radix_in = RADIX_HEX;
            end
            if (do_digit) begin
               radix_in = radix_eff;
               if (dig_ok) begin
                  acc_in  = acc_mac;
                  mark_in = pos_sat;
                  seen_in = 1'b1;
               end
            end
         end
      end
   end

   assign value      = acc_ff;
   assign end_offset = seen_ff ? mark_ff : '0;
   assign converted  = seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         radix_ff <= '0;
         acc_ff   <= '0;
         pos_ff   <= '0;
         mark_ff  <= '0;
         seen_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
         mark_ff  <= mark_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

/* design/asu_out_stage.sv */
// asu_out_stage: result register feeding the result channel
// depends on asu_pkg and asu_rsp_if
module asu_out_stage
   import asu_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [VALUE_BITS-1:0]  value,
   input  logic [OFFSET_BITS-1:0] end_offset,
   input  logic                   converted,
   output logic                   free,
   asu_rsp_if.source              rsp_bus
);

   logic                   valid_ff, valid_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   conv_ff, conv_in;

   // slot can take a word when empty or being drained this cycle
   assign free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in  = valid_ff;
      value_in  = value_ff;
      offset_in = offset_ff;
      conv_in   = conv_ff;
      if (load) begin
         valid_in  = 1'b1;
         value_in  = value;
         offset_in = end_offset;
         conv_in   = converted;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff  <= value_in;
      offset_ff <= offset_in;
      conv_ff   <= conv_in;
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.value      = value_ff;
   assign rsp_bus.end_offset = offset_ff;
   assign rsp_bus.converted  = conv_ff;

endmodule

/* design/ascii_to_unsigned_parser.sv */
// ascii_to_unsigned_parser: streaming ascii to unsigned converter, top level
// the terminating character word is held in the input register, and the
// result word is then registered in the result register
// throughput: one character per cycle while the result slot is free
// reset: parser back to whitespace skip, base select 0 (prefix detect)
// depends on asu_pkg, asu_ifs, asu_in_stage, asu_core, asu_out_stage
module ascii_to_unsigned_parser
   import asu_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   asu_req_if.sink   req_bus,
   asu_rsp_if.source rsp_bus,
   asu_csr_if.sink   csr_bus
);

   logic [RADIX_BITS-1:0]  base_select_ff, base_select_in;
   logic                   held_valid;
   logic [CHAR_BITS-1:0]   held_char;
   logic                   out_free, fire, emit;
   logic [VALUE_BITS-1:0]  value;
   logic [OFFSET_BITS-1:0] end_offset;
   logic                   converted;

   // base select register, always writable
   assign csr_bus.ready  = 1'b1;
   assign base_select_in = (csr_bus.valid && csr_bus.ready) ? csr_bus.data : base_select_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_select_ff <= '0;
      end else begin
         base_select_ff <= base_select_in;
      end
   end

   // a held character is processed when the result slot can take a word
   assign fire = held_valid && out_free;

   asu_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (fire),
      .held_valid (held_valid),
      .held_char  (held_char)
   );

   asu_core #(.OFFSET_BITS(OFFSET_BITS)) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .character   (held_char),
      .base_select (base_select_ff),
      .emit        (emit),
      .value       (value),
      .end_offset  (end_offset),
      .converted   (converted)
   );

   asu_out_stage #(.OFFSET_BITS(OFFSET_BITS)) u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (emit),
      .value      (value),
      .end_offset (end_offset),
      .converted  (converted),
      .free       (out_free),
      .rsp_bus    (rsp_bus)
   );

endmodule
